/* rtl/plt_pkg.sv */
// ----------------------------------------------------------------------------
// Positional list table package
// Shared constants, operation codes and transaction types for the list table.
// ----------------------------------------------------------------------------
package plt_pkg;

  // Default number of list slots.
  localparam int PLT_CAPACITY = 64;

  // Fixed field widths of the request and response transactions.
  localparam int PLT_FUNC_W  = 3;
  localparam int PLT_POS_W   = 7;
  localparam int PLT_WORD_W  = 32;
  localparam int PLT_FIDX_W  = 6;
  localparam int PLT_COUNT_W = 7;

  // Operation codes carried in the request.
  typedef enum logic [PLT_FUNC_W-1:0] {
    FN_INSERT   = 3'd0,
    FN_APPEND   = 3'd1,
    FN_DELETE   = 3'd2,
    FN_LOCATE   = 3'd3,
    FN_RETRIEVE = 3'd4,
    FN_CLEAR    = 3'd5
  } plt_func_e;

  // Shift command broadcast to every cell.
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } plt_cmd_e;

  // Request transaction.
  typedef struct packed {
    logic [PLT_FUNC_W-1:0] func;
    logic [PLT_POS_W-1:0]  position;
    logic [PLT_WORD_W-1:0] value;
  } plt_req_t;

  // Response transaction.
  typedef struct packed {
    logic                   ok;
    logic [PLT_WORD_W-1:0]  word_out;
    logic [PLT_FIDX_W-1:0]  found_index;
    logic [PLT_COUNT_W-1:0] count;
  } plt_rsp_t;

endpackage

/* rtl/plt_cell.sv */
// ----------------------------------------------------------------------------
// Positional list table cell
// Holds one list slot, shifts it with its neighbors on insert and remove, and
// passes a registered search probe on to the next cell every cycle.
// ----------------------------------------------------------------------------
module plt_cell
  import plt_pkg::*;
#(
  parameter int CAPACITY = PLT_CAPACITY,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1),
  localparam int CMD_W = 2 + IDX_W + PLT_WORD_W,
  localparam int PRB_W = 3 + 2 * IDX_W + PLT_WORD_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IDX_W-1:0]      cell_idx,
  input  logic [CNT_W-1:0]      list_count,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [PLT_WORD_W-1:0] left_entry,
  input  logic [PLT_WORD_W-1:0] right_entry,
  output logic [PLT_WORD_W-1:0] entry,
  input  logic [PRB_W-1:0]      probe_in,
  output logic [PRB_W-1:0]      probe_out
);

  typedef struct packed {
    plt_cmd_e              op;
    logic [IDX_W-1:0]      pidx;
    logic [PLT_WORD_W-1:0] value;
  } plt_shift_t;

  typedef struct packed {
    logic                  valid;
    logic                  locate;
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      tgt;
    logic [PLT_WORD_W-1:0] data;
  } plt_probe_t;

  plt_shift_t sh;
  plt_probe_t pin;
  plt_probe_t probe_next;
  plt_probe_t probe_q;
  logic       in_list;

  assign sh        = plt_shift_t'(cmd);
  assign pin       = plt_probe_t'(probe_in);
  assign probe_out = PRB_W'(probe_q);
  assign in_list   = CNT_W'(cell_idx) < list_count;

  // Slot update: open a gap on insert, close it on remove.
  always_ff @(posedge clk) begin
    case (sh.op)
      CMD_INSERT: begin
        if (cell_idx > sh.pidx) begin
          entry <= left_entry;
        end else if (cell_idx == sh.pidx) begin
          entry <= sh.value;
        end
      end
      CMD_REMOVE: begin
        if (cell_idx >= sh.pidx) begin
          entry <= right_entry;
        end
      end
      default: begin
      end
    endcase
  end

  // Probe step: a locate takes the first match, a read picks up its target.
  always_comb begin
    probe_next = pin;
    if (pin.valid && in_list) begin
      if (pin.locate) begin
        if (!pin.hit && entry == pin.data) begin
          probe_next.hit     = 1'b1;
          probe_next.hit_idx = cell_idx;
        end
      end else if (pin.tgt == cell_idx) begin
        probe_next.hit  = 1'b1;
        probe_next.data = entry;
      end
    end
  end

  // Probe register; only the valid flag is control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_q.valid <= 1'b0;
    end else begin
      probe_q <= probe_next;
    end
  end

endmodule

/* rtl/positional_list_table.sv */
// ----------------------------------------------------------------------------
// Positional list table
// Ordered list of data words held in a row of cells, with insert, append,
// delete, locate, retrieve and clear operations.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (valid/ready); each request transaction gives
//   exactly one response transaction on rsp (valid/ready), in order.
//   Insert, append, clear, unused codes and out-of-range delete or retrieve
//   finish at once: the response is registered on acceptance when rsp is
//   free. Locate, and delete or retrieve in range, send a probe down the row
//   of CAPACITY cells, one cell per cycle. A delete closes the gap in the
//   same cycle the probe leaves the last cell.
//   req_ready is high whenever no probe is in flight and no finished result
//   is parked. Immediate operations sustain one per cycle while rsp drains;
//   a probe operation holds req_ready low until its probe leaves the last cell.
//   A stalled rsp holds its response; one more result may park in a holding
//   register, after which req_ready stays low until rsp is taken.
//   Reset empties the list and drops any pending response; stored words are
//   not cleared, and none is read before it is written.
// ----------------------------------------------------------------------------
module positional_list_table
  import plt_pkg::*;
#(
  parameter int CAPACITY = PLT_CAPACITY
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  plt_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output plt_rsp_t rsp
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMD_W = 2 + IDX_W + PLT_WORD_W;
  localparam int PRB_W = 3 + 2 * IDX_W + PLT_WORD_W;
  localparam int PW    = (PLT_POS_W > CNT_W ? PLT_POS_W : CNT_W) + 1;

  typedef struct packed {
    plt_cmd_e              op;
    logic [IDX_W-1:0]      pidx;
    logic [PLT_WORD_W-1:0] value;
  } plt_shift_t;

  typedef struct packed {
    logic                  valid;
    logic                  locate;
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      tgt;
    logic [PLT_WORD_W-1:0] data;
  } plt_probe_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e     state;
  logic [CNT_W-1:0] cnt;
  logic       scan_del;
  plt_rsp_t   res;

  logic       accept;
  logic       out_free;
  logic [PW-1:0] pos_x;
  logic [PW-1:0] cnt_x;
  logic [PW-1:0] pos_m1;
  logic       full;
  logic       ins_ok;
  logic       del_ok;
  logic       ret_ok;
  logic       launch;
  plt_rsp_t   imm_res;
  logic [CNT_W-1:0] imm_cnt;
  plt_rsp_t   scan_res;
  plt_shift_t sh;
  plt_probe_t head;
  plt_probe_t tail;

  logic [PLT_WORD_W-1:0] entries [CAPACITY];
  logic [PRB_W-1:0]      probes  [CAPACITY+1];

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  // Range checks on the request position.
  assign pos_x  = PW'(req.position);
  assign cnt_x  = PW'(cnt);
  assign pos_m1 = pos_x - 1'b1;
  assign full   = (cnt == CNT_W'(CAPACITY));
  assign ins_ok = !full && (pos_x != '0) && (pos_x <= cnt_x + 1'b1);
  assign del_ok = (pos_x != '0) && (pos_x <= cnt_x);
  assign ret_ok = (pos_x < cnt_x);

  // Decode the request into an immediate result or a probe launch.
  always_comb begin
    launch  = 1'b0;
    imm_res = '0;
    imm_cnt = cnt;
    head    = '0;
    head.data = req.value;
    unique case (req.func)
      FN_INSERT: begin
        imm_res.ok = ins_ok;
        if (ins_ok) imm_cnt = cnt + 1'b1;
      end
      FN_APPEND: begin
        imm_res.ok = !full;
        if (!full) imm_cnt = cnt + 1'b1;
      end
      FN_DELETE: begin
        launch   = del_ok;
        head.tgt = pos_m1[IDX_W-1:0];
      end
      FN_LOCATE: begin
        launch      = 1'b1;
        head.locate = 1'b1;
      end
      FN_RETRIEVE: begin
        launch   = ret_ok;
        head.tgt = pos_x[IDX_W-1:0];
      end
      FN_CLEAR: begin
        imm_res.ok = 1'b1;
        imm_cnt    = '0;
      end
      default: begin
      end
    endcase
    imm_res.count = PLT_COUNT_W'(imm_cnt);
    head.valid    = accept && launch;
  end

  // Shift command: inserts on acceptance, removals when the probe returns.
  always_comb begin
    sh       = '0;
    sh.value = req.value;
    if (accept && req.func == FN_INSERT && ins_ok) begin
      sh.op   = CMD_INSERT;
      sh.pidx = pos_m1[IDX_W-1:0];
    end else if (accept && req.func == FN_APPEND && !full) begin
      sh.op   = CMD_INSERT;
      sh.pidx = cnt[IDX_W-1:0];
    end else if (state == S_SCAN && tail.valid && scan_del) begin
      sh.op   = CMD_REMOVE;
      sh.pidx = tail.tgt;
    end
  end

  // Result of a probe leaving the last cell.
  always_comb begin
    scan_res    = '0;
    scan_res.ok = tail.hit;
    if (tail.locate) begin
      scan_res.found_index = PLT_FIDX_W'(tail.hit_idx);
      scan_res.count       = PLT_COUNT_W'(cnt);
    end else begin
      scan_res.word_out = tail.data;
      scan_res.count    = scan_del ? PLT_COUNT_W'(cnt - 1'b1) : PLT_COUNT_W'(cnt);
    end
  end

  // Row of cells.
  assign probes[0] = PRB_W'(head);
  assign tail      = plt_probe_t'(probes[CAPACITY]);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    plt_cell #(
      .CAPACITY (CAPACITY)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cell_idx    (IDX_W'(i)),
      .list_count  (cnt),
      .cmd         (CMD_W'(sh)),
      .left_entry  (entries[(i == 0) ? 0 : i - 1]),
      .right_entry (entries[(i == CAPACITY - 1) ? i : i + 1]),
      .entry       (entries[i]),
      .probe_in    (probes[i]),
      .probe_out   (probes[i+1])
    );
  end

  // Control state, count and response registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            scan_del <= (req.func == FN_DELETE);
            if (launch) begin
              state <= S_SCAN;
            end else begin
              cnt <= imm_cnt;
              if (out_free) begin
                rsp       <= imm_res;
                rsp_valid <= 1'b1;
              end else begin
                res   <= imm_res;
                state <= S_RESULT;
              end
            end
          end
        end
        S_SCAN: begin
          if (tail.valid) begin
            if (scan_del) begin
              cnt <= cnt - 1'b1;
            end
            if (out_free) begin
              rsp       <= scan_res;
              rsp_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              res   <= scan_res;
              state <= S_RESULT;
            end
          end
        end
        S_RESULT: begin
          if (out_free) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The count never exceeds the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("list count above capacity");

  // No probe leaves the row while the block is taking requests.
  a_no_stray_probe: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !tail.valid)
    else $error("probe returned outside a scan");

  // A delete or retrieve probe is launched only in range, so it always hits.
  a_read_hits: assert property (@(posedge clk) disable iff (rst)
    (tail.valid && !tail.locate) |-> tail.hit)
    else $error("read probe missed its target");

  // A successful insert grows the list by one.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req.func == FN_INSERT && ins_ok) |=> cnt == $past(cnt) + 1'b1)
    else $error("insert did not grow the list");

  // A finished probe result reaches the response register or the holding slot.
  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && tail.valid) |=> (state == S_IDLE || state == S_RESULT))
    else $error("scan did not complete");

endmodule

/* sim/positional_list_table_tb.sv */
// ----------------------------------------------------------------------------
// Positional list table testbench
// Drives request transactions with random gaps and drains response
// transactions with random stalls. A scoreboard keeps a shadow copy of the
// list, predicts every response and compares each one field by field, in order.
// ----------------------------------------------------------------------------
module positional_list_table_tb;
  import plt_pkg::*;

  // Function codes that the block does not define.
  localparam logic [PLT_FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [PLT_FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  localparam int     HALF_PERIOD    = 6;
  localparam int     RANDOM_ITEMS   = 2000;
  localparam int     DRAIN_CYCLES   = PLT_CAPACITY + 16;
  localparam longint TIMEOUT_CYCLES = 1_200_000;
  localparam int     MAX_REPORTS    = 10;

  // Operation mix of one random phase.
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_e;

  // Shadow list plus the queue of responses still owed by the block.
  class list_table_scoreboard;
    logic [PLT_WORD_W-1:0] shadow_words [PLT_CAPACITY];
    int unsigned           shadow_count;
    plt_rsp_t              due_rsp [$];
    int unsigned           mismatches;

    function new();
      shadow_count = 0;
      mismatches   = 0;
    endfunction

    // Insert a word at a 1-based position and move later entries up.
    function bit place_word(int unsigned pos, logic [PLT_WORD_W-1:0] word);
      int unsigned i;
      if (shadow_count >= PLT_CAPACITY || pos < 1 || pos > shadow_count + 1) begin
        return 1'b0;
      end
      for (i = shadow_count; i >= pos; i--) begin
        shadow_words[i] = shadow_words[i - 1];
      end
      shadow_words[pos - 1] = word;
      shadow_count++;
      return 1'b1;
    endfunction

    // Apply an accepted request to the shadow list and queue its response.
    function void take_request(plt_req_t r);
      plt_rsp_t    e;
      int unsigned pos;
      int unsigned i;
      e   = '0;
      pos = r.position;
      case (r.func)
        FN_INSERT: begin
          e.ok = place_word(pos, r.value);
        end
        FN_APPEND: begin
          e.ok = place_word(shadow_count + 1, r.value);
        end
        FN_DELETE: begin
          if (pos >= 1 && pos <= shadow_count) begin
            e.word_out = shadow_words[pos - 1];
            for (i = pos - 1; i + 1 < shadow_count; i++) begin
              shadow_words[i] = shadow_words[i + 1];
            end
            shadow_count--;
            e.ok = 1'b1;
          end
        end
        FN_LOCATE: begin
          for (i = 0; i < shadow_count; i++) begin
            if (!e.ok && shadow_words[i] == r.value) begin
              e.ok          = 1'b1;
              e.found_index = PLT_FIDX_W'(i);
            end
          end
        end
        FN_RETRIEVE: begin
          if (pos < shadow_count) begin
            e.word_out = shadow_words[pos];
            e.ok       = 1'b1;
          end
        end
        FN_CLEAR: begin
          shadow_count = 0;
          e.ok         = 1'b1;
        end
        default: begin
        end
      endcase
      e.count = PLT_COUNT_W'(shadow_count);
      due_rsp.push_back(e);
    endfunction

    // Compare one accepted response with the oldest prediction.
    function void check_answer(plt_rsp_t got);
      plt_rsp_t e;
      if (due_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected response: ok=%0d word=%08h index=%0d count=%0d",
                   got.ok, got.word_out, got.found_index, got.count);
        end
        return;
      end
      e = due_rsp.pop_front();
      if (got.ok !== e.ok || got.word_out !== e.word_out ||
          got.found_index !== e.found_index || got.count !== e.count) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Mismatch: expected ok=%0d word=%08h index=%0d count=%0d",
                   e.ok, e.word_out, e.found_index, e.count);
          $display("          actual   ok=%0d word=%08h index=%0d count=%0d",
                   got.ok, got.word_out, got.found_index, got.count);
        end
      end
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  plt_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  plt_rsp_t rsp;

  list_table_scoreboard  board;
  logic [PLT_WORD_W-1:0] word_pool [8];
  bit                    tx_quiet  = 1'b0;
  bit                    rx_quiet  = 1'b0;
  bit                    stim_done = 1'b0;

  positional_list_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Free-running clock.
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Idle cycles before the next transaction; quiet stretches have none.
  function automatic int unsigned draw_gap(inout bit quiet);
    if ($urandom_range(0, 99) == 0) begin
      quiet = ~quiet;
    end
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  // Offer one request and wait until the block takes it.
  task automatic send_op(input logic [PLT_FUNC_W-1:0] func, input int unsigned pos,
                         input logic [PLT_WORD_W-1:0] value);
    int unsigned gap;
    plt_req_t    item;
    item.func     = func;
    item.position = PLT_POS_W'(pos);
    item.value    = value;
    gap = draw_gap(tx_quiet);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.take_request(item);
  endtask

  // Accept one response after a random stall and check it.
  task automatic take_answer();
    int unsigned gap;
    gap = draw_gap(rx_quiet);
    if (stim_done && board.due_rsp.size() == 0) begin
      gap = 0;
    end
    if (gap > 0) begin
      rsp_ready <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rsp_ready <= 1'b1;
    @(posedge clk);
    while (!rsp_valid) @(posedge clk);
    board.check_answer(rsp);
  endtask

  // Data words: mostly from a small pool so that locate hits and duplicates occur.
  function automatic logic [PLT_WORD_W-1:0] pick_word();
    if ($urandom_range(0, 2) == 0) begin
      return $urandom();
    end
    return word_pool[$urandom_range(0, 7)];
  endfunction

  // Positions: mostly legal, some on the boundaries, a few anywhere in the field.
  function automatic int unsigned pick_pos(int lo, int hi);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (hi < lo || sel < 5) begin
      return $urandom_range(0, 127);
    end
    if (sel < 20) begin
      case ($urandom_range(0, 2))
        0:       return 0;
        1:       return hi;
        default: return hi + 1;
      endcase
    end
    return $urandom_range(hi, lo);
  endfunction

  // One random request, weighted by the mix of the current phase.
  task automatic send_random(input mix_e mode);
    int unsigned           sel;
    int                    n;
    int unsigned           ins_end;
    int unsigned           app_end;
    int unsigned           del_end;
    logic [PLT_WORD_W-1:0] word;
    n    = board.shadow_count;
    word = pick_word();
    case (mode)
      MIX_GROW: begin
        ins_end = 35; app_end = 60; del_end = 68;
      end
      MIX_SHRINK: begin
        ins_end = 10; app_end = 18; del_end = 68;
      end
      default: begin
        ins_end = 25; app_end = 40; del_end = 68;
      end
    endcase
    sel = $urandom_range(0, 99);
    if (sel < ins_end) begin
      send_op(FN_INSERT, pick_pos(1, n + 1), word);
    end else if (sel < app_end) begin
      send_op(FN_APPEND, $urandom_range(0, 127), word);
    end else if (sel < del_end) begin
      send_op(FN_DELETE, pick_pos(1, n), word);
    end else if (sel < 82) begin
      // Usually look for a word that is stored.
      if (n > 0 && $urandom_range(0, 9) < 7) begin
        word = board.shadow_words[$urandom_range(0, n - 1)];
      end
      send_op(FN_LOCATE, $urandom_range(0, 127), word);
    end else if (sel < 96) begin
      send_op(FN_RETRIEVE, pick_pos(0, n - 1), word);
    end else if (sel < 97) begin
      send_op(FN_CLEAR, $urandom_range(0, 127), word);
    end else if (sel < 98) begin
      send_op(FN_SPARE_6, $urandom_range(0, 127), word);
    end else begin
      send_op(FN_SPARE_7, $urandom_range(0, 127), word);
    end
  endtask

  // Stimulus and end of run.
  initial begin
    int unsigned sent;
    mix_e        mode;
    int unsigned phase_len;
    board        = new();
    word_pool[0] = 32'h0000_0000;
    word_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < 8; k++) begin
      word_pool[k] = $urandom();
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, boundary positions, extreme words, unused codes.
    send_op(FN_RETRIEVE, 0, 32'h0000_0000);
    send_op(FN_DELETE, 1, 32'h0000_0000);
    send_op(FN_LOCATE, 0, 32'h0000_0000);
    send_op(FN_INSERT, 0, 32'h1111_1111);
    send_op(FN_INSERT, 2, 32'h2222_2222);
    send_op(FN_INSERT, 1, 32'h0000_0000);
    send_op(FN_INSERT, 1, 32'hFFFF_FFFF);
    send_op(FN_APPEND, 127, 32'h5A5A_5A5A);
    send_op(FN_INSERT, 4, 32'hA5A5_A5A5);
    send_op(FN_INSERT, 2, 32'hFFFF_FFFF);
    send_op(FN_LOCATE, 0, 32'hFFFF_FFFF);
    send_op(FN_LOCATE, 64, 32'hA5A5_A5A5);
    send_op(FN_LOCATE, 0, 32'h1234_5678);
    send_op(FN_RETRIEVE, 0, 32'h0000_0000);
    send_op(FN_RETRIEVE, 4, 32'h0000_0000);
    send_op(FN_RETRIEVE, 5, 32'h0000_0000);
    send_op(FN_RETRIEVE, 127, 32'hFFFF_FFFF);
    send_op(FN_DELETE, 0, 32'h0000_0000);
    send_op(FN_DELETE, 6, 32'h0000_0000);
    send_op(FN_DELETE, 127, 32'h0000_0000);
    send_op(FN_DELETE, 1, 32'h0000_0000);
    send_op(FN_DELETE, 4, 32'h0000_0000);
    send_op(FN_SPARE_6, 127, 32'hFFFF_FFFF);
    send_op(FN_SPARE_7, 64, 32'hFFFF_FFFF);
    send_op(FN_CLEAR, 64, 32'hFFFF_FFFF);
    send_op(FN_RETRIEVE, 0, 32'h0000_0000);

    // Random phases that fill, drain or churn the list.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode      = mix_e'($urandom_range(0, 2));
      phase_len = $urandom_range(40, 200);
      repeat (phase_len) begin
        send_random(mode);
        sent++;
      end
    end
    req_valid <= 1'b0;
    stim_done = 1'b1;

    // Wait for every outstanding response, then watch for strays.
    while (board.due_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Response side runs for the whole test once reset is released.
  initial begin
    wait (rst == 1'b0);
    forever take_answer();
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
rtl/plt_pkg.sv
rtl/plt_cell.sv
rtl/positional_list_table.sv
sim/positional_list_table_tb.sv
